/* rtl/rsi_pkg.sv */
// Shared types and constants for the Wilder RSI stream block.
// Used by rsi_div and wilder_rsi_stream; no dependencies.
package rsi_pkg;

    localparam int RET_W    = 32;   // input return width
    localparam int AVG_W    = 40;   // running sum / average width
    localparam int LEN_W    = 8;    // window length register width
    localparam int RSI_W    = 23;   // Q7.16 result width
    localparam int REM_W    = 41;   // divisor / remainder width (gain + loss)
    localparam int STEP_W   = 6;    // divider step counter width

    localparam logic [LEN_W-1:0] WINDOW_RESET = 8'd14;

    // 100 * 2^16: full scale of the Q7.16 result
    localparam logic [RSI_W-1:0] RSI_FULL = 23'd6553600;

    // Quotient bits produced per division
    localparam logic [STEP_W-1:0] AVG_STEPS = 6'd40;
    localparam logic [STEP_W-1:0] RSI_STEPS = 6'd23;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;    // quotient bits to produce
        logic [REM_W-1:0]  divisor;
        logic [REM_W-1:0]  num_hi;   // initial partial remainder, below divisor
        logic [AVG_W-1:0]  num_lo;   // remaining dividend bits, left-justified
    } div_req_t;

    typedef struct packed {
        logic             done;      // one-cycle pulse, quotient valid
        logic [AVG_W-1:0] quotient;  // low 'steps' bits hold the quotient
    } div_sts_t;

endpackage

/* rtl/rsi_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the averaging and RSI steps; uses rsi_pkg types.
module rsi_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  rsi_pkg::div_req_t req,
    output rsi_pkg::div_sts_t sts
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [rsi_pkg::STEP_W-1:0]  cnt_reg;
    logic [rsi_pkg::REM_W-1:0]   rem_reg;
    logic [rsi_pkg::AVG_W-1:0]   quo_reg;
    logic [rsi_pkg::REM_W-1:0]   div_reg;

    logic [rsi_pkg::REM_W:0]     shifted;
    logic [rsi_pkg::REM_W+1:0]   diff;
    logic                        qbit;
    logic [rsi_pkg::REM_W-1:0]   rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[rsi_pkg::AVG_W-1]};
        diff     = {1'b0, shifted} - {2'b00, div_reg};
        qbit     = ~diff[rsi_pkg::REM_W+1];
        rem_next = qbit ? diff[rsi_pkg::REM_W-1:0] : shifted[rsi_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rsi_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num_hi;
            quo_reg <= req.num_lo;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[rsi_pkg::AVG_W-2:0], qbit};
        end
    end

    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

endmodule

/* rtl/wilder_rsi_stream.sv */
// Streaming Wilder RSI. Returns that only fill the window never leave the idle state.
// An item that yields a result takes two 40-bit and, unless gain + loss is zero,
// one 23-bit quotient through the shared restoring divider; a new item is taken
// only after the result has moved to the output register.
// Reset (async, active low) clears the series state and sets window_length 14;
// the result register holds while the output is stalled.
module wilder_rsi_stream
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [rsi_pkg::LEN_W-1:0]   cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        series_start,
    input  logic signed [rsi_pkg::RET_W-1:0] daily_return,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rsi_pkg::RSI_W-1:0]   rsi_value,
    output logic                        rsi_undefined
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVG  = 3'd1;
    localparam logic [2:0] ST_WAITG = 3'd2;
    localparam logic [2:0] ST_DIVL  = 3'd3;
    localparam logic [2:0] ST_WAITL = 3'd4;
    localparam logic [2:0] ST_RSI   = 3'd5;
    localparam logic [2:0] ST_WAITR = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    localparam int PROD_W = rsi_pkg::AVG_W + rsi_pkg::LEN_W;
    localparam int NUM_W  = rsi_pkg::AVG_W + rsi_pkg::RSI_W;

    logic [2:0]                 state_reg, state_next;
    logic [rsi_pkg::LEN_W-1:0]  window_length_reg;
    logic [rsi_pkg::LEN_W-1:0]  cnt_reg;
    logic                       smooth_reg;
    logic                       win_item_reg;   // item was taken while the window was filling
    logic [rsi_pkg::AVG_W-1:0]  gain_avg_reg;
    logic [rsi_pkg::AVG_W-1:0]  loss_avg_reg;
    logic [rsi_pkg::RET_W-1:0]  xg_reg;
    logic [rsi_pkg::RET_W-1:0]  xl_reg;
    logic [rsi_pkg::RSI_W-1:0]  res_value_reg;
    logic                       res_undef_reg;
    logic                       out_valid_reg;
    logic [rsi_pkg::RSI_W-1:0]  out_value_reg;
    logic                       out_undef_reg;

    logic                       accept;
    logic                       out_free;
    logic [rsi_pkg::LEN_W-1:0]  p_eff;
    logic [rsi_pkg::LEN_W-1:0]  p_m1;
    logic [rsi_pkg::RET_W-1:0]  in_gain;
    logic [rsi_pkg::RET_W-1:0]  in_loss;
    logic [rsi_pkg::AVG_W-1:0]  gain_sum;
    logic [rsi_pkg::AVG_W-1:0]  loss_sum;
    logic [rsi_pkg::LEN_W:0]    cnt_inc;
    logic                       win_full;
    logic [PROD_W-1:0]          smooth_num;
    logic [rsi_pkg::REM_W-1:0]  total;
    logic [NUM_W-1:0]           rsi_num;
    logic [rsi_pkg::AVG_W-1:0]  sel_avg;
    logic [rsi_pkg::RET_W-1:0]  sel_x;

    rsi_pkg::div_req_t          div_req;
    rsi_pkg::div_sts_t          div_sts;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign p_eff = (window_length_reg == '0) ? rsi_pkg::LEN_W'(1) : window_length_reg;
    assign p_m1  = p_eff - 1'b1;

    always_comb
    begin
        if (daily_return[rsi_pkg::RET_W-1])
        begin
            in_gain = '0;
            in_loss = rsi_pkg::RET_W'(-daily_return);
        end
        else
        begin
            in_gain = daily_return;
            in_loss = '0;
        end
    end

    assign gain_sum = gain_avg_reg + rsi_pkg::AVG_W'(in_gain);
    assign loss_sum = loss_avg_reg + rsi_pkg::AVG_W'(in_loss);
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign win_full = (cnt_inc >= {1'b0, p_eff});

    // One smoothing numerator at a time: gain in ST_DIVG, loss in ST_DIVL
    assign sel_avg    = (state_reg == ST_DIVL) ? loss_avg_reg : gain_avg_reg;
    assign sel_x      = (state_reg == ST_DIVL) ? xl_reg : xg_reg;
    assign smooth_num = PROD_W'(sel_avg) * PROD_W'(p_m1) + PROD_W'(sel_x);

    assign total   = rsi_pkg::REM_W'(gain_avg_reg) + rsi_pkg::REM_W'(loss_avg_reg);
    assign rsi_num = NUM_W'(gain_avg_reg) * NUM_W'(rsi_pkg::RSI_FULL);

    always_comb
    begin
        div_req = '0;
        unique case (state_reg) inside
            ST_DIVG, ST_DIVL:
            begin
                div_req.start   = 1'b1;
                div_req.steps   = rsi_pkg::AVG_STEPS;
                div_req.divisor = rsi_pkg::REM_W'(p_eff);
                if (win_item_reg)
                begin
                    div_req.num_lo = sel_avg;
                end
                else
                begin
                    // quotient fits 40 bits, so the top bits are already below p
                    div_req.num_hi = rsi_pkg::REM_W'(smooth_num[PROD_W-1:rsi_pkg::AVG_W]);
                    div_req.num_lo = smooth_num[rsi_pkg::AVG_W-1:0];
                end
            end
            ST_RSI:
            begin
                div_req.start   = (total != '0);
                div_req.steps   = rsi_pkg::RSI_STEPS;
                div_req.divisor = total;
                // quotient below 2^23, so the top 40 bits are below total
                div_req.num_hi  = rsi_pkg::REM_W'(rsi_num[NUM_W-1:rsi_pkg::RSI_W]);
                div_req.num_lo  = {rsi_num[rsi_pkg::RSI_W-1:0],
                                   (rsi_pkg::AVG_W - rsi_pkg::RSI_W)'(0)};
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    rsi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !series_start)
                begin
                    if (smooth_reg || win_full)
                    begin
                        state_next = ST_DIVG;
                    end
                end
            end
            ST_DIVG:  state_next = ST_WAITG;
            ST_WAITG: state_next = div_sts.done ? ST_DIVL : ST_WAITG;
            ST_DIVL:  state_next = ST_WAITL;
            ST_WAITL: state_next = div_sts.done ? ST_RSI : ST_WAITL;
            ST_RSI:   state_next = (total == '0) ? ST_EMIT : ST_WAITR;
            ST_WAITR: state_next = div_sts.done ? ST_EMIT : ST_WAITR;
            ST_EMIT:  state_next = out_free ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_length_reg <= rsi_pkg::WINDOW_RESET;
            cnt_reg           <= '0;
            smooth_reg        <= 1'b0;
            win_item_reg      <= 1'b0;
            gain_avg_reg      <= '0;
            loss_avg_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write_en)
            begin
                window_length_reg <= cfg_write_data;
            end

            if (accept)
            begin
                if (series_start)
                begin
                    cnt_reg      <= '0;
                    smooth_reg   <= 1'b0;
                    gain_avg_reg <= '0;
                    loss_avg_reg <= '0;
                end
                else if (!smooth_reg)
                begin
                    gain_avg_reg <= gain_sum;
                    loss_avg_reg <= loss_sum;
                    cnt_reg      <= cnt_inc[rsi_pkg::LEN_W-1:0];
                    win_item_reg <= 1'b1;
                    if (win_full)
                    begin
                        smooth_reg <= 1'b1;
                    end
                end
                else
                begin
                    win_item_reg <= 1'b0;
                end
            end

            if (state_reg == ST_WAITG && div_sts.done)
            begin
                gain_avg_reg <= div_sts.quotient;
            end
            if (state_reg == ST_WAITL && div_sts.done)
            begin
                loss_avg_reg <= div_sts.quotient;
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xg_reg <= in_gain;
            xl_reg <= in_loss;
        end
        if (state_reg == ST_RSI)
        begin
            res_value_reg <= '0;
            res_undef_reg <= (total == '0);
        end
        if (state_reg == ST_WAITR && div_sts.done)
        begin
            res_value_reg <= div_sts.quotient[rsi_pkg::RSI_W-1:0];
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_value_reg <= res_value_reg;
            out_undef_reg <= res_undef_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rsi_value     = out_value_reg;
    assign rsi_undefined = out_undef_reg;

    // The divider reports completion only while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_WAITG || state_reg == ST_WAITL ||
                          state_reg == ST_WAITR))
        else $error("divider done outside a wait state");

    // The ratio can never exceed full scale
    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rsi_value <= rsi_pkg::RSI_FULL))
        else $error("rsi_value above 100");

    // An undefined result always carries a zero value
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rsi_undefined) |-> (rsi_value == '0))
        else $error("undefined result with nonzero value");

    // A result is produced only once smoothing is active
    a_emit_smooth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> smooth_reg)
        else $error("result before window complete");

endmodule

/* bench/tb_wilder_rsi_stream.sv */
// Self-checking bench for wilder_rsi_stream: directed and random return series,
// with a scoreboard class that predicts each RSI result. Depends on rsi_pkg.
// The input sees random valid gaps and the output random stalls.
module tb_wilder_rsi_stream;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 150;   // longer than one result computation
    localparam int RANDOM_ITEMS  = 750;
    localparam int CALM_AFTER    = 650;

    typedef struct packed {
        logic [rsi_pkg::RSI_W-1:0] value;
        logic                      undefined;
    } rsi_expect_t;

    typedef enum int {MOVE_MIXED, MOVE_UP, MOVE_DOWN, MOVE_FLAT, MOVE_WIDE} move_kind_t;

    class rsi_scoreboard_t;
        logic [rsi_pkg::LEN_W-1:0] win_len  = rsi_pkg::WINDOW_RESET;
        logic [8:0]                seen     = '0;
        logic [rsi_pkg::AVG_W-1:0] gain_avg = '0;
        logic [rsi_pkg::AVG_W-1:0] loss_avg = '0;
        rsi_expect_t               expected[$];
        int                        errors   = 0;

        function void set_window(logic [rsi_pkg::LEN_W-1:0] len);
            win_len = len;
        endfunction

        // Advance the predicted state by one accepted transfer.
        function void note_input(logic start, logic [rsi_pkg::RET_W-1:0] ret);
            logic [63:0] p, g, l, total;
            rsi_expect_t e;
            p = (win_len == 0) ? 64'd1 : 64'(win_len);
            if (start)
            begin
                seen = '0;
                gain_avg = '0;
                loss_avg = '0;
                return;
            end
            g = '0;
            l = '0;
            if (ret[rsi_pkg::RET_W-1])
                l = 64'(rsi_pkg::RET_W'(~ret + 1'b1));
            else
                g = 64'(ret);
            if (seen < 9'd256)
            begin
                gain_avg = rsi_pkg::AVG_W'(64'(gain_avg) + g);
                loss_avg = rsi_pkg::AVG_W'(64'(loss_avg) + l);
                seen = seen + 1'b1;
                if (64'(seen) < p)
                    return;
                gain_avg = rsi_pkg::AVG_W'(64'(gain_avg) / p);
                loss_avg = rsi_pkg::AVG_W'(64'(loss_avg) / p);
                seen = 9'd256;
            end
            else
            begin
                gain_avg = rsi_pkg::AVG_W'((64'(gain_avg) * (p - 1) + g) / p);
                loss_avg = rsi_pkg::AVG_W'((64'(loss_avg) * (p - 1) + l) / p);
            end
            total = 64'(gain_avg) + 64'(loss_avg);
            if (total == 0)
            begin
                e.value = '0;
                e.undefined = 1'b1;
            end
            else
            begin
                e.value = rsi_pkg::RSI_W'((64'(gain_avg) * 64'd100 * 64'd65536) / total);
                e.undefined = 1'b0;
            end
            expected.insert(expected.size(), e);
        endfunction

        function void check_result(logic [rsi_pkg::RSI_W-1:0] value, logic undefined);
            rsi_expect_t e;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected result rsi_value %0d rsi_undefined %0b",
                         $time, value, undefined);
                errors++;
                return;
            end
            e = expected.pop_front();
            if (value !== e.value)
            begin
                $display("%0t: rsi_value expected %0d got %0d", $time, e.value, value);
                errors++;
            end
            if (undefined !== e.undefined)
            begin
                $display("%0t: rsi_undefined expected %0b got %0b",
                         $time, e.undefined, undefined);
                errors++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write_en;
    logic [rsi_pkg::LEN_W-1:0]        cfg_write_data;
    logic                             in_valid;
    logic                             in_stall;
    logic                             series_start;
    logic signed [rsi_pkg::RET_W-1:0] daily_return;
    logic                             out_valid;
    logic                             out_stall;
    logic [rsi_pkg::RSI_W-1:0]        rsi_value;
    logic                             rsi_undefined;

    rsi_scoreboard_t           sb = new();
    bit                        calm = 1'b0;
    logic [rsi_pkg::LEN_W-1:0] cur_len = rsi_pkg::WINDOW_RESET;

    // Window of 14 at reset with no series start; extremes and bit patterns.
    logic [rsi_pkg::RET_W-1:0] fill_returns [16] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h0100_0000, 32'hFF00_0000, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678,
        32'hEDCB_A988, 32'h0080_0000, 32'h7FFF_FFFF, 32'h8000_0000
    };

    wilder_rsi_stream uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .series_start   (series_start),
        .daily_return   (daily_return),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rsi_value      (rsi_value),
        .rsi_undefined  (rsi_undefined)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                sb.set_window(cfg_write_data);
            if (in_valid && !in_stall)
                sb.note_input(series_start, daily_return);
            if (out_valid && !out_stall)
                sb.check_result(rsi_value, rsi_undefined);
        end
    end

    // Output stall bursts; none once the run turns calm.
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic send_item(input logic start, input logic [rsi_pkg::RET_W-1:0] ret);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        series_start <= start;
        daily_return <= ret;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold off input until all results are in and the block has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [rsi_pkg::LEN_W-1:0] len);
        wait_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= len;
        cur_len = len;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [rsi_pkg::RET_W-1:0] next_return(move_kind_t kind);
        logic [rsi_pkg::RET_W-1:0] mag;
        mag = $urandom_range(0, 32'h0400_0000);
        case (kind)
            MOVE_UP:   return mag;
            MOVE_DOWN: return -mag;
            MOVE_FLAT: return '0;
            MOVE_WIDE:
            begin
                case ($urandom_range(0, 7))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    default: return $urandom;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    return '0;
                return $urandom_range(0, 1) ? mag : -mag;
            end
        endcase
    endfunction

    function automatic logic [rsi_pkg::LEN_W-1:0] pick_window();
        case ($urandom_range(0, 19))
            0:       return 8'd1;
            1:       return 8'd0;
            2:       return 8'd255;
            default: return rsi_pkg::LEN_W'($urandom_range(2, 16));
        endcase
    endfunction

    initial
    begin
        int         counted;
        int         left;
        int         phase_items;
        move_kind_t kind;

        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        series_start   <= 1'b0;
        daily_return   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state acts as a fresh series: first return is summed.
        foreach (fill_returns[i])
            send_item(1'b0, fill_returns[i]);

        // Window of one: flat gives the undefined flag, gains only give full scale.
        write_window(8'd1);
        send_item(1'b1, 32'h7FFF_FFFF);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'h0001_0000);
        send_item(1'b0, 32'h8000_0000);

        // Zero length behaves as one.
        write_window(8'd0);
        send_item(1'b0, 32'h0000_0001);
        send_item(1'b0, 32'hFFFF_FFFF);

        write_window(8'd2);
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'h0200_0000);

        // Longest window once, in full.
        write_window(8'd255);
        send_item(1'b1, $urandom);
        counted = 0;
        repeat (265)
        begin
            send_item(1'b0, next_return($urandom_range(0, 1) ? MOVE_WIDE : MOVE_MIXED));
            counted++;
        end

        // Series carry across phases, so windows change while filling and smoothing.
        left = 0;
        kind = MOVE_MIXED;
        while (counted < RANDOM_ITEMS)
        begin
            write_window(pick_window());
            phase_items = $urandom_range(20, 60);
            repeat (phase_items)
            begin
                calm = (counted >= CALM_AFTER);
                if (left == 0)
                begin
                    left = $urandom_range(1, ((cur_len == 0) ? 1 : int'(cur_len)) + 24);
                    kind = move_kind_t'($urandom_range(0, 4));
                    if ($urandom_range(0, 9) != 0)
                        send_item(1'b1, $urandom);
                end
                send_item(1'b0, next_return(kind));
                counted++;
                left--;
            end
        end

        calm = 1'b1;
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/rsi_pkg.sv
rtl/rsi_div.sv
rtl/wilder_rsi_stream.sv
bench/tb_wilder_rsi_stream.sv
